// ----- hdl/segx2d_pkg.sv -----
// Package for the 2D segment intersection pipeline.
// Holds the default coordinate width and the per-item flag group.
// No dependencies.
package segx2d_pkg;

	localparam int COORD_BITS_DEF = 24;

	typedef struct packed {
		logic hit;
		logic neg_x;
		logic neg_y;
	} flags_t;

endpackage

// ----- hdl/segx2d_front.sv -----
// Front end of the segment intersection pipeline: differences, cross products,
// range tests and the numerator-times-direction products, six stages.
// Depends on segx2d_pkg.
module segx2d_front #(
	parameter int CW = segx2d_pkg::COORD_BITS_DEF,
	localparam int MW = 2 * CW + 1,
	localparam int PW = 3 * CW + 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CW-1:0]     a_start_x,
	input  logic signed [CW-1:0]     a_start_y,
	input  logic signed [CW-1:0]     a_end_x,
	input  logic signed [CW-1:0]     a_end_y,
	input  logic signed [CW-1:0]     b_start_x,
	input  logic signed [CW-1:0]     b_start_y,
	input  logic signed [CW-1:0]     b_end_x,
	input  logic signed [CW-1:0]     b_end_y,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [PW-1:0]            prod_x,
	output logic [PW-1:0]            prod_y,
	output logic [MW-1:0]            den_mag,
	output logic [CW-1:0]            base_x,
	output logic [CW-1:0]            base_y,
	output segx2d_pkg::flags_t       flags
);
	import segx2d_pkg::*;

	localparam int DW   = CW + 1;
	localparam int XW   = 2 * DW;
	localparam int LO_W = CW + 1;
	localparam int HI_W = MW - LO_W;

	logic en1, en2, en3, en4, en5, en6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// stage 1
	logic        [CW-1:0] sax_s1, say_s1;
	logic signed [DW-1:0] dax_s1, day_s1, dbx_s1, dby_s1, d0x_s1, d0y_s1;
	// stage 2
	logic        [CW-1:0] sax_s2, say_s2;
	logic signed [DW-1:0] dax_s2, day_s2;
	logic signed [XW-1:0] pd1_s2, pd2_s2, pa1_s2, pa2_s2, pb1_s2, pb2_s2;
	// stage 3
	logic        [CW-1:0] sax_s3, say_s3;
	logic signed [DW-1:0] dax_s3, day_s3;
	logic signed [XW-1:0] den_s3, na_s3, nb_s3;
	// stage 4
	logic [CW-1:0] sax_s4, say_s4;
	logic [CW-1:0] dax_mag_s4, day_mag_s4;
	logic          dax_neg_s4, day_neg_s4;
	logic [MW-1:0] den_mag_s4, na_mag_s4, nb_mag_s4;
	logic          den_neg_s4, na_neg_s4, nb_neg_s4;
	logic          den_zero_s4, na_zero_s4, nb_zero_s4;
	// stage 5
	logic [CW-1:0]      sax_s5, say_s5;
	logic [MW-1:0]      den_mag_s5;
	logic [LO_W+CW-1:0] lo_x_s5, lo_y_s5;
	logic [HI_W+CW-1:0] hi_x_s5, hi_y_s5;
	flags_t             flags_s5;
	// stage 6
	logic [CW-1:0] sax_s6, say_s6;
	logic [MW-1:0] den_mag_s6;
	logic [PW-1:0] prod_x_s6, prod_y_s6;
	flags_t        flags_s6;

	logic signed [DW-1:0] dax_c, day_c, dbx_c, dby_c, d0x_c, d0y_c;
	logic hit_c;

	assign en6 = !v_s6 || out_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	assign dax_c = DW'(a_end_x) - DW'(a_start_x);
	assign day_c = DW'(a_end_y) - DW'(a_start_y);
	assign dbx_c = DW'(b_end_x) - DW'(b_start_x);
	assign dby_c = DW'(b_end_y) - DW'(b_start_y);
	assign d0x_c = DW'(a_start_x) - DW'(b_start_x);
	assign d0y_c = DW'(a_start_y) - DW'(b_start_y);

	assign hit_c = !den_zero_s4
		&& (na_zero_s4 || (na_neg_s4 == den_neg_s4)) && (na_mag_s4 <= den_mag_s4)
		&& (nb_zero_s4 || (nb_neg_s4 == den_neg_s4)) && (nb_mag_s4 <= den_mag_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sax_s1 <= a_start_x;
			say_s1 <= a_start_y;
			dax_s1 <= dax_c;
			day_s1 <= day_c;
			dbx_s1 <= dbx_c;
			dby_s1 <= dby_c;
			d0x_s1 <= d0x_c;
			d0y_s1 <= d0y_c;
		end
		if (en2) begin
			sax_s2 <= sax_s1;
			say_s2 <= say_s1;
			dax_s2 <= dax_s1;
			day_s2 <= day_s1;
			pd1_s2 <= dbx_s1 * day_s1;
			pd2_s2 <= dby_s1 * dax_s1;
			pa1_s2 <= d0x_s1 * dby_s1;
			pa2_s2 <= d0y_s1 * dbx_s1;
			pb1_s2 <= d0x_s1 * day_s1;
			pb2_s2 <= d0y_s1 * dax_s1;
		end
		if (en3) begin
			sax_s3 <= sax_s2;
			say_s3 <= say_s2;
			dax_s3 <= dax_s2;
			day_s3 <= day_s2;
			den_s3 <= pd1_s2 - pd2_s2;
			na_s3  <= pa1_s2 - pa2_s2;
			nb_s3  <= pb1_s2 - pb2_s2;
		end
		if (en4) begin
			sax_s4      <= sax_s3;
			say_s4      <= say_s3;
			dax_neg_s4  <= dax_s3[DW-1];
			day_neg_s4  <= day_s3[DW-1];
			dax_mag_s4  <= dax_s3[DW-1] ? CW'(-dax_s3) : CW'(dax_s3);
			day_mag_s4  <= day_s3[DW-1] ? CW'(-day_s3) : CW'(day_s3);
			den_neg_s4  <= den_s3[XW-1];
			na_neg_s4   <= na_s3[XW-1];
			nb_neg_s4   <= nb_s3[XW-1];
			den_mag_s4  <= den_s3[XW-1] ? MW'(-den_s3) : MW'(den_s3);
			na_mag_s4   <= na_s3[XW-1] ? MW'(-na_s3) : MW'(na_s3);
			nb_mag_s4   <= nb_s3[XW-1] ? MW'(-nb_s3) : MW'(nb_s3);
			den_zero_s4 <= (den_s3 == '0);
			na_zero_s4  <= (na_s3 == '0);
			nb_zero_s4  <= (nb_s3 == '0);
		end
		if (en5) begin
			sax_s5         <= sax_s4;
			say_s5         <= say_s4;
			den_mag_s5     <= den_mag_s4;
			flags_s5.hit   <= hit_c;
			flags_s5.neg_x <= na_neg_s4 ^ den_neg_s4 ^ dax_neg_s4;
			flags_s5.neg_y <= na_neg_s4 ^ den_neg_s4 ^ day_neg_s4;
			lo_x_s5        <= na_mag_s4[LO_W-1:0] * dax_mag_s4;
			hi_x_s5        <= na_mag_s4[MW-1:LO_W] * dax_mag_s4;
			lo_y_s5        <= na_mag_s4[LO_W-1:0] * day_mag_s4;
			hi_y_s5        <= na_mag_s4[MW-1:LO_W] * day_mag_s4;
		end
		if (en6) begin
			sax_s6     <= sax_s5;
			say_s6     <= say_s5;
			den_mag_s6 <= den_mag_s5;
			flags_s6   <= flags_s5;
			prod_x_s6  <= PW'(lo_x_s5) + (PW'(hi_x_s5) << LO_W);
			prod_y_s6  <= PW'(lo_y_s5) + (PW'(hi_y_s5) << LO_W);
		end
	end

	assign out_valid = v_s6;
	assign prod_x    = prod_x_s6;
	assign prod_y    = prod_y_s6;
	assign den_mag   = den_mag_s6;
	assign base_x    = sax_s6;
	assign base_y    = say_s6;
	assign flags     = flags_s6;

	a_quotient_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && flags_s6.hit |->
			(prod_x_s6 < (PW'(den_mag_s6) << CW)) && (prod_y_s6 < (PW'(den_mag_s6) << CW)))
		else $error("product exceeds quotient range on a hit");

endmodule

// ----- hdl/segx2d_div.sv -----
// Pipelined restoring divider, one quotient bit per stage for both axes.
// Carries the base point and flags alongside. Depends on segx2d_pkg.
module segx2d_div #(
	parameter int CW = segx2d_pkg::COORD_BITS_DEF,
	localparam int MW = 2 * CW + 1,
	localparam int PW = 3 * CW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PW-1:0]        prod_x,
	input  logic [PW-1:0]        prod_y,
	input  logic [MW-1:0]        den_mag,
	input  logic [CW-1:0]        base_x,
	input  logic [CW-1:0]        base_y,
	input  segx2d_pkg::flags_t   flags,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CW-1:0]        quo_x,
	output logic [CW-1:0]        quo_y,
	output logic [CW-1:0]        out_base_x,
	output logic [CW-1:0]        out_base_y,
	output segx2d_pkg::flags_t   out_flags
);
	import segx2d_pkg::*;

	logic          v_s     [CW];
	logic          en      [CW];
	logic [PW-1:0] rem_x_s [CW];
	logic [PW-1:0] rem_y_s [CW];
	logic [CW-1:0] quo_x_s [CW];
	logic [CW-1:0] quo_y_s [CW];
	logic [MW-1:0] den_s   [CW];
	logic [CW-1:0] bx_s    [CW];
	logic [CW-1:0] by_s    [CW];
	flags_t        flags_s [CW];

	for (genvar j = 0; j < CW; j++) begin : g_step
		localparam int B = CW - 1 - j;
		logic          pv;
		logic [PW-1:0] rx, ry, dsh;
		logic [CW-1:0] qx, qy;
		logic [MW-1:0] pden;
		logic [CW-1:0] pbx, pby;
		flags_t        pfl;
		logic          ge_x, ge_y;

		if (j == 0) begin : g_first
			assign pv   = in_valid;
			assign rx   = prod_x;
			assign ry   = prod_y;
			assign qx   = '0;
			assign qy   = '0;
			assign pden = den_mag;
			assign pbx  = base_x;
			assign pby  = base_y;
			assign pfl  = flags;
		end else begin : g_next
			assign pv   = v_s[j-1];
			assign rx   = rem_x_s[j-1];
			assign ry   = rem_y_s[j-1];
			assign qx   = quo_x_s[j-1];
			assign qy   = quo_y_s[j-1];
			assign pden = den_s[j-1];
			assign pbx  = bx_s[j-1];
			assign pby  = by_s[j-1];
			assign pfl  = flags_s[j-1];
		end

		if (j == CW - 1) begin : g_last
			assign en[j] = !v_s[j] || out_ready;
		end else begin : g_mid
			assign en[j] = !v_s[j] || en[j+1];
		end

		assign dsh  = PW'(pden) << B;
		assign ge_x = (rx >= dsh);
		assign ge_y = (ry >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en[j]) begin
				v_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_x_s[j] <= ge_x ? rx - dsh : rx;
				rem_y_s[j] <= ge_y ? ry - dsh : ry;
				quo_x_s[j] <= qx | (CW'(ge_x) << B);
				quo_y_s[j] <= qy | (CW'(ge_y) << B);
				den_s[j]   <= pden;
				bx_s[j]    <= pbx;
				by_s[j]    <= pby;
				flags_s[j] <= pfl;
			end
		end
	end

	assign in_ready   = en[0];
	assign out_valid  = v_s[CW-1];
	assign quo_x      = quo_x_s[CW-1];
	assign quo_y      = quo_y_s[CW-1];
	assign out_base_x = bx_s[CW-1];
	assign out_base_y = by_s[CW-1];
	assign out_flags  = flags_s[CW-1];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[CW-1] && flags_s[CW-1].hit |->
			(rem_x_s[CW-1] < PW'(den_s[CW-1])) && (rem_y_s[CW-1] < PW'(den_s[CW-1])))
		else $error("division remainder not below divisor");

endmodule

// ----- hdl/segment_intersection_2d_top.sv -----
// Top level of the 2D segment intersection pipeline.
// Instantiates segx2d_front and segx2d_div and holds the output stage.
// Depends on segx2d_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_ready  | a_start_x/y, a_end_x/y, b_start_x/y, b_end_x/y
//  output  | out_valid / out_ready| hit, point_x, point_y
//
// One item per cycle sustained while out_ready holds; the stages are, in order:
// six front stages, one divider stage per quotient bit, one output stage.
// Every stage has its own valid bit and advances when empty or when the next one
// advances, so bubbles close up under a stalled output.
// Reset clears all valid bits; nothing else needs clearing.
module segment_intersection_2d_top #(
	parameter int COORD_BITS = segx2d_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] a_start_x,
	input  logic signed [COORD_BITS-1:0] a_start_y,
	input  logic signed [COORD_BITS-1:0] a_end_x,
	input  logic signed [COORD_BITS-1:0] a_end_y,
	input  logic signed [COORD_BITS-1:0] b_start_x,
	input  logic signed [COORD_BITS-1:0] b_start_y,
	input  logic signed [COORD_BITS-1:0] b_end_x,
	input  logic signed [COORD_BITS-1:0] b_end_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y
);
	import segx2d_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int MW = 2 * CW + 1;
	localparam int PW = 3 * CW + 1;

	logic          f_valid, f_ready;
	logic [PW-1:0] f_prod_x, f_prod_y;
	logic [MW-1:0] f_den;
	logic [CW-1:0] f_base_x, f_base_y;
	flags_t        f_flags;

	logic          d_valid, d_ready;
	logic [CW-1:0] d_quo_x, d_quo_y, d_base_x, d_base_y;
	flags_t        d_flags;

	logic [CW-1:0] off_x, off_y;
	logic          valid_q, hit_q;
	logic [CW-1:0] point_x_q, point_y_q;

	segx2d_front #(.CW(CW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.a_start_x (a_start_x),
		.a_start_y (a_start_y),
		.a_end_x   (a_end_x),
		.a_end_y   (a_end_y),
		.b_start_x (b_start_x),
		.b_start_y (b_start_y),
		.b_end_x   (b_end_x),
		.b_end_y   (b_end_y),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.prod_x    (f_prod_x),
		.prod_y    (f_prod_y),
		.den_mag   (f_den),
		.base_x    (f_base_x),
		.base_y    (f_base_y),
		.flags     (f_flags)
	);

	segx2d_div #(.CW(CW)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (f_valid),
		.in_ready   (f_ready),
		.prod_x     (f_prod_x),
		.prod_y     (f_prod_y),
		.den_mag    (f_den),
		.base_x     (f_base_x),
		.base_y     (f_base_y),
		.flags      (f_flags),
		.out_valid  (d_valid),
		.out_ready  (d_ready),
		.quo_x      (d_quo_x),
		.quo_y      (d_quo_y),
		.out_base_x (d_base_x),
		.out_base_y (d_base_y),
		.out_flags  (d_flags)
	);

	assign d_ready = !valid_q || out_ready;

	// apply the sign to the quotient
	assign off_x = d_flags.neg_x ? (~d_quo_x + CW'(1)) : d_quo_x;
	assign off_y = d_flags.neg_y ? (~d_quo_y + CW'(1)) : d_quo_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (d_ready) begin
			valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (d_ready) begin
			hit_q     <= d_flags.hit;
			point_x_q <= d_flags.hit ? d_base_x + off_x : '0;
			point_y_q <= d_flags.hit ? d_base_y + off_y : '0;
		end
	end

	assign out_valid = valid_q;
	assign hit       = hit_q;
	assign point_x   = point_x_q;
	assign point_y   = point_y_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with an empty output stage");

	a_miss_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> (point_x == '0) && (point_y == '0))
		else $error("miss carries a nonzero point");

endmodule
